// ===== rtl/fqsm_pkg.sv =====
// fqsm_pkg: shared types, constants and codes for the fifo queue with search and max
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fqsm_pkg;

	// queue geometry
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int POS_W  = 6;

	// request modes
	localparam logic [2:0] MODE_PUSH   = 3'd0;
	localparam logic [2:0] MODE_POP    = 3'd1;
	localparam logic [2:0] MODE_SEARCH = 3'd2;
	localparam logic [2:0] MODE_MAX    = 3'd3;
	localparam logic [2:0] MODE_DUMP   = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_MISS  = 2'd3;

	// request word
	typedef struct packed {
		logic [2:0]               mode;
		logic signed [WORD_W-1:0] value;
	} fqsm_in_t;

	// result word
	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data_out;
		logic [POS_W-1:0]         position;
		logic                     last;
	} fqsm_out_t;

	// chain operations
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_PUSH   = 2'd1,
		CMD_SHIFT  = 2'd2,
		CMD_ROTATE = 2'd3
	} chain_op_t;

	// command broadcast to every cell
	typedef struct packed {
		chain_op_t                op;
		logic signed [WORD_W-1:0] wdata;
		logic [CNT_W-1:0]         count;
	} chain_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fqsm_cell.sv =====
// fqsm_cell: one storage cell of the queue chain, holds the entry at its position from head
// depends on fqsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fqsm_cell
	import fqsm_pkg::*;
(
	input  wire logic                     clk,
	input  wire chain_cmd_t               cmd,
	input  wire logic [IDX_W-1:0]         cell_idx,
	input  wire logic signed [WORD_W-1:0] next_data,
	input  wire logic signed [WORD_W-1:0] head_data,
	output logic signed [WORD_W-1:0]      data
);

	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] pos_plus1;
	logic signed [WORD_W-1:0] data_q;

	assign pos       = CNT_W'(cell_idx);
	assign pos_plus1 = pos + CNT_W'(1);
	assign data      = data_q;

	// load from push, neighbor or the wrapped head word
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_PUSH: begin
				if (pos == cmd.count) begin
					data_q <= cmd.wdata;
				end
			end
			CMD_SHIFT: begin
				data_q <= next_data;
			end
			CMD_ROTATE: begin
				if (pos_plus1 == cmd.count) begin
					data_q <= head_data;
				end else if (pos_plus1 < cmd.count) begin
					data_q <= next_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/fqsm_ctrl.sv =====
// fqsm_ctrl: request decode, fill count, walk sequencer and result register
// depends on fqsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fqsm_ctrl
	import fqsm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire fqsm_in_t                 in_word,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output fqsm_out_t                     out_word,
	input  wire logic signed [WORD_W-1:0] head_data,
	output chain_cmd_t                    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [2:0]               walk_mode_q;
	logic signed [WORD_W-1:0] key_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_pos_q;
	logic signed [WORD_W-1:0] best_q;
	logic                     out_valid_q;
	fqsm_out_t                out_q;

	logic                     slot_free;
	logic                     accept;
	logic                     is_empty;
	logic                     is_full;
	logic                     last_step;
	logic                     emit_step;
	logic                     step_en;
	logic                     match;
	logic signed [WORD_W-1:0] best_cand;
	logic                     emit;
	fqsm_out_t                res;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// walk step bookkeeping: head cell is looked at once per rotation
	assign last_step = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign emit_step = (walk_mode_q == MODE_DUMP) || last_step;
	assign step_en   = (state_q == ST_WALK) && (!emit_step || slot_free);
	assign match     = (head_data == key_q);
	assign best_cand = ((idx_q == '0) || (head_data > best_q)) ? head_data : best_q;

	// request decode and walk control
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cmd.op      = CMD_HOLD;
		cmd.wdata   = in_word.value;
		cmd.count   = count_q;
		emit        = 1'b0;
		res         = '0;
		res.last    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_word.mode == MODE_PUSH) begin
						emit = 1'b1;
						if (is_full) begin
							res.status = STAT_FULL;
						end else begin
							res.status = STAT_OK;
							cmd.op     = CMD_PUSH;
							count_d    = count_q + CNT_W'(1);
						end
					end else if (in_word.mode == MODE_POP || in_word.mode == MODE_SEARCH ||
					             in_word.mode == MODE_MAX || in_word.mode == MODE_DUMP) begin
						if (is_empty) begin
							emit       = 1'b1;
							res.status = STAT_EMPTY;
						end else if (in_word.mode == MODE_POP) begin
							emit         = 1'b1;
							res.status   = STAT_OK;
							res.data_out = head_data;
							cmd.op       = CMD_SHIFT;
							count_d      = count_q - CNT_W'(1);
						end else begin
							state_d = ST_WALK;
						end
					end
				end
			end
			ST_WALK: begin
				if (step_en) begin
					cmd.op = CMD_ROTATE;
					if (last_step) begin
						state_d = ST_IDLE;
					end
					if (emit_step) begin
						emit = 1'b1;
						case (walk_mode_q)
							MODE_SEARCH: begin
								if (hit_q) begin
									res.status   = STAT_OK;
									res.position = POS_W'(hit_pos_q);
								end else if (match) begin
									res.status   = STAT_OK;
									res.position = POS_W'(idx_q);
								end else begin
									res.status = STAT_MISS;
								end
							end
							MODE_MAX: begin
								res.status   = STAT_OK;
								res.data_out = best_cand;
							end
							default: begin
								res.status   = STAT_OK;
								res.data_out = head_data;
								res.position = POS_W'(idx_q);
								res.last     = last_step;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers and result word
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		if (accept) begin
			walk_mode_q <= in_word.mode;
			key_q       <= in_word.value;
			idx_q       <= '0;
			hit_q       <= 1'b0;
		end else if (step_en) begin
			idx_q  <= idx_q + IDX_W'(1);
			best_q <= best_cand;
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_pos_q <= idx_q;
			end
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (count_q != '0))
		else $error("walk on empty queue");

	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CNT_W'(idx_q) < count_q))
		else $error("walk index past stored entries");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word.mode == MODE_PUSH && !is_full) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not grow the queue");

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_search_and_max_core.sv =====
// fifo_queue_with_search_and_max_core: top level, a row of DEPTH cells plus the controller
// depends on fqsm_pkg, fqsm_cell, fqsm_ctrl
// push, pop and empty/full results are registered into the output register on accept
// push and pop are handled at accept; search, max and dump rotate the cell row through the head cell
//   once, one entry per cycle unless a result step waits for the output slot, and hold the input until done
// reset: arst_n clears the fill count, the sequencer and the output valid; cell contents are kept
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_search_and_max_core
	import fqsm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire fqsm_in_t  in_word,
	output logic           out_valid,
	input  wire logic      out_ready,
	output fqsm_out_t      out_word
);

	chain_cmd_t               cmd;
	logic signed [WORD_W-1:0] cell_data [DEPTH];

	// controller
	fqsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.head_data (cell_data[0]),
		.cmd       (cmd)
	);

	// row of cells, each passes its word toward the head
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [WORD_W-1:0] nxt;
		if (g == DEPTH - 1) begin : g_tail
			assign nxt = cell_data[g];
		end else begin : g_mid
			assign nxt = cell_data[g+1];
		end
		fqsm_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.cell_idx  (IDX_W'(g)),
			.next_data (nxt),
			.head_data (cell_data[0]),
			.data      (cell_data[g])
		);
	end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for fifo_queue_with_search_and_max_core
// depends on fqsm_pkg; a shadow queue class predicts every result word, plain tasks drive the ports

module tb_top;
	import fqsm_pkg::*;

	// request modes the block ignores
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	localparam int RANDOM_WORDS = 310;
	localparam int PHASE_WORDS  = 30;
	localparam int DRAIN_CYCLES = 4 * DEPTH;
	localparam int MAX_REPORTS  = 10;

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	// receiver stall styles, rotated by bits 9:8 of the cycle counter
	typedef enum logic [1:0] {
		RX_OPEN   = 2'd0,
		RX_COIN   = 2'd1,
		RX_COMB   = 2'd2,
		RX_SPARSE = 2'd3
	} rx_style_t;

	// shadow copy of the ring and the result words it must produce
	class fifo_shadow;
		logic signed [WORD_W-1:0] ring [DEPTH];
		int unsigned              head_idx;
		int unsigned              tail_idx;
		int unsigned              fill;
		fqsm_out_t                awaited_results [$];
		int                       errors;

		function new();
			head_idx = 0;
			tail_idx = 0;
			fill     = 0;
			errors   = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function fqsm_out_t make_result(logic [1:0] status, logic signed [WORD_W-1:0] data,
				int unsigned pos, logic last);
			fqsm_out_t r;
			r.status   = status;
			r.data_out = data;
			r.position = POS_W'(pos);
			r.last     = last;
			return r;
		endfunction

		function logic signed [WORD_W-1:0] entry_at(int unsigned k);
			return ring[(head_idx + k) % DEPTH];
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// work out the results of one accepted request word
		function void note_request(fqsm_in_t w);
			logic signed [WORD_W-1:0] best;
			bit                       hit;
			if (w.mode > MODE_DUMP)
				return;
			if (w.mode == MODE_PUSH) begin
				if (fill == DEPTH) begin
					awaited_results.push_back(make_result(STAT_FULL, '0, 0, 1'b1));
				end else begin
					ring[tail_idx] = w.value;
					tail_idx = (tail_idx + 1) % DEPTH;
					fill++;
					awaited_results.push_back(make_result(STAT_OK, '0, 0, 1'b1));
				end
				return;
			end
			if (fill == 0) begin
				awaited_results.push_back(make_result(STAT_EMPTY, '0, 0, 1'b1));
				return;
			end
			case (w.mode)
				MODE_POP: begin
					awaited_results.push_back(make_result(STAT_OK, ring[head_idx], 0, 1'b1));
					head_idx = (head_idx + 1) % DEPTH;
					fill--;
				end
				MODE_SEARCH: begin
					// first match counted from the head
					hit = 1'b0;
					for (int unsigned k = 0; k < fill; k++) begin
						if (!hit && entry_at(k) == w.value) begin
							awaited_results.push_back(make_result(STAT_OK, '0, k, 1'b1));
							hit = 1'b1;
						end
					end
					if (!hit)
						awaited_results.push_back(make_result(STAT_MISS, '0, 0, 1'b1));
				end
				MODE_MAX: begin
					best = entry_at(0);
					for (int unsigned k = 1; k < fill; k++)
						if (entry_at(k) > best)
							best = entry_at(k);
					awaited_results.push_back(make_result(STAT_OK, best, 0, 1'b1));
				end
				default: begin
					// dump: head to tail, last flag on the final entry
					for (int unsigned k = 0; k < fill; k++)
						awaited_results.push_back(make_result(STAT_OK, entry_at(k), k,
							k + 1 == fill));
				end
			endcase
		endfunction

		function void flag(string what, fqsm_out_t want, fqsm_out_t got);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$write("%s: expected st %0d data %0d pos %0d last %0d",
					what, want.status, want.data_out, want.position, want.last);
				$display(", got st %0d data %0d pos %0d last %0d",
					got.status, got.data_out, got.position, got.last);
			end
		endfunction

		// compare one accepted result word with the oldest prediction
		function void check_result(fqsm_out_t got);
			fqsm_out_t want;
			if (awaited_results.size() == 0) begin
				flag("unexpected word", '0, got);
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.data_out !== want.data_out ||
					got.position !== want.position || got.last !== want.last)
				flag("mismatch", want, got);
		endfunction

		// predictions never answered
		function void close_out();
			while (awaited_results.size() != 0)
				flag("missing word", awaited_results.pop_front(), '0);
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	fqsm_in_t    in_word   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	fqsm_out_t   out_word;

	fifo_shadow  shadow;
	int          sent_count = 0;
	int          burst_left = 0;
	int unsigned rx_cycle   = 0;

	fifo_queue_with_search_and_max_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case (rx_style_t'(rx_cycle[9:8]))
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
			RX_COMB:   out_ready <= ((rx_cycle % 7) >= 3);
			default:   out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.check_result(out_word);
	end

	function automatic fqsm_in_t make_req(logic [2:0] mode, logic signed [WORD_W-1:0] value);
		fqsm_in_t w;
		w.mode  = mode;
		w.value = value;
		return w;
	endfunction

	// extremes, a narrow band for duplicates, or anything
	function automatic logic signed [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0:       return WORD_MIN;
					1:       return WORD_MAX;
					2:       return '0;
					default: return -1;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// hold one word on the input until accepted
	task automatic send_word(input fqsm_in_t w);
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		shadow.note_request(w);
		if (w.mode <= MODE_DUMP)
			sent_count++;
	endtask

	// input idle for a number of cycles, junk on the payload
	task automatic pause(input int cycles);
		fqsm_in_t junk;
		junk.mode  = 3'($urandom);
		junk.value = $urandom;
		in_valid <= 1'b0;
		in_word  <= junk;
		repeat (cycles) @(posedge clk);
	endtask

	// send in bursts with random gaps between them
	task automatic send_paced(input fqsm_in_t w);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 7))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(10, 24);
				default: gap = $urandom_range(1, 5);
			endcase
			if (gap > 0)
				pause(gap);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		send_word(w);
	endtask

	// stop sending until every predicted word has come back
	task automatic settle();
		pause(1);
		while (shadow.pending() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	task automatic run_directed();
		// empty queue for every reading mode
		send_paced(make_req(MODE_POP, '0));
		send_paced(make_req(MODE_SEARCH, 32'sd5));
		send_paced(make_req(MODE_MAX, '0));
		send_paced(make_req(MODE_DUMP, '0));
		// unused modes are dropped
		send_paced(make_req(MODE_SPARE_LO, WORD_MAX));
		send_paced(make_req(MODE_SPARE_LO + 3'd1, WORD_MIN));
		send_paced(make_req(MODE_SPARE_HI, -1));
		// extremes, with a duplicate of the minimum
		send_paced(make_req(MODE_PUSH, WORD_MIN));
		send_paced(make_req(MODE_PUSH, WORD_MAX));
		send_paced(make_req(MODE_PUSH, '0));
		send_paced(make_req(MODE_PUSH, -1));
		send_paced(make_req(MODE_PUSH, WORD_MIN));
		// hits, first of two equal entries, and a miss
		send_paced(make_req(MODE_SEARCH, WORD_MAX));
		send_paced(make_req(MODE_SEARCH, WORD_MIN));
		send_paced(make_req(MODE_SEARCH, 32'sd12345));
		send_paced(make_req(MODE_MAX, '0));
		send_paced(make_req(MODE_DUMP, '0));
		send_paced(make_req(MODE_POP, '0));
		// head moved: same searches again
		send_paced(make_req(MODE_SEARCH, WORD_MIN));
		send_paced(make_req(MODE_MAX, '0));
		send_paced(make_req(MODE_DUMP, '0));
	endtask

	// random words with a given share of pushes
	task automatic run_phase(input int push_pct, input int words);
		fqsm_in_t                 w;
		logic signed [WORD_W-1:0] key;
		int                       stop;
		stop = sent_count + words;
		while (sent_count < stop) begin
			if ($urandom_range(0, 31) == 0) begin
				w = make_req(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), $urandom);
			end else if ($urandom_range(0, 99) < push_pct) begin
				w = make_req(MODE_PUSH, pick_value());
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: w = make_req(MODE_POP, $urandom);
					4, 5, 6: begin
						if (shadow.fill != 0 && $urandom_range(0, 2) != 0)
							key = shadow.entry_at($urandom_range(0, shadow.fill - 1));
						else
							key = pick_value();
						w = make_req(MODE_SEARCH, key);
					end
					7:       w = make_req(MODE_MAX, $urandom);
					default: w = make_req(MODE_DUMP, $urandom);
				endcase
			end
			send_paced(w);
		end
	endtask

	// main sequence
	initial begin
		int stop;
		int phase;
		bit held;
		shadow = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle();

		stop  = sent_count + RANDOM_WORDS;
		phase = 0;
		held  = 1'b0;
		while (sent_count < stop) begin
			// the first phase of every five fills the queue, the others wander between full and empty
			case (phase % 5)
				0:       run_phase(95, PHASE_WORDS);
				1:       run_phase(50, PHASE_WORDS);
				2:       run_phase(20, PHASE_WORDS);
				3:       run_phase(70, PHASE_WORDS);
				default: run_phase(35, PHASE_WORDS);
			endcase
			phase++;
			if (!held && sent_count >= stop - RANDOM_WORDS / 2) begin
				settle();
				held = 1'b1;
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		shadow.close_out();
		if (shadow.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
